// ===== design/inplace_glyph_glow_blur_top_assert.svh =====
// Assertion macros shared by the checker of the glyph glow blur block.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef INPLACE_GLYPH_GLOW_BLUR_TOP_ASSERT_SVH
`define INPLACE_GLYPH_GLOW_BLUR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IGGB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IGGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error(msg);

`endif

// ===== design/iggb_pkg.sv =====
// Types, codes and the sequencer program of the glyph glow blur block.
// No dependencies; imported by the top level and its checker.
package iggb_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  localparam logic [1:0] REG_TILE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TILE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PASS_COUNT  = 2'd2;

  localparam logic [7:0] PixMax = 8'd255;
  localparam int unsigned SumShift = 3;

  typedef logic [3:0] step_t;

  localparam step_t ST_IDLE = 4'd0;
  localparam step_t ST_PASS = 4'd1;
  localparam step_t ST_PIX  = 4'd2;
  localparam step_t ST_RD0  = 4'd3;
  localparam step_t ST_RD8  = 4'd11;
  localparam step_t ST_WR   = 4'd12;
  localparam step_t ST_ADV  = 4'd13;
  localparam step_t ST_DONE = 4'd14;

  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_RUN_START = 3'd1,
    C_PASS_DONE = 3'd2,
    C_SKIP      = 3'd3,
    C_LAST      = 3'd4
  } cond_e;

  typedef enum logic [3:0] {
    NB_SELF   = 4'd0,
    NB_RIGHT  = 4'd1,
    NB_LEFT   = 4'd2,
    NB_DOWN   = 4'd3,
    NB_UP     = 4'd4,
    NB_DOWN_R = 4'd5,
    NB_UP_L   = 4'd6,
    NB_DOWN_L = 4'd7,
    NB_UP_R   = 4'd8
  } nbr_e;

  typedef struct packed {
    logic  in_ready;
    cond_e cond;
    step_t tgt_t;
    step_t tgt_f;
    logic  pass_init;
    logic  acc_clr;
    logic  rd_en;
    nbr_e  nbr;
    logic  wr_en;
    logic  adv;
    logic  push;
  } uc_word_t;

  function automatic uc_word_t ucode(step_t s);
    uc_word_t cw;
    cw = '0;
    unique case (s) inside
      ST_IDLE: begin
        cw.in_ready = 1'b1;
        cw.cond     = C_RUN_START;
        cw.tgt_t    = ST_PASS;
        cw.tgt_f    = ST_IDLE;
      end
      ST_PASS: begin
        cw.cond      = C_PASS_DONE;
        cw.tgt_t     = ST_DONE;
        cw.tgt_f     = ST_PIX;
        cw.pass_init = 1'b1;
      end
      ST_PIX: begin
        cw.cond    = C_SKIP;
        cw.tgt_t   = ST_ADV;
        cw.tgt_f   = ST_RD0;
        cw.acc_clr = 1'b1;
      end
      [ST_RD0:ST_RD8]: begin
        cw.cond  = C_ALWAYS;
        cw.tgt_t = s + 4'd1;
        cw.tgt_f = s + 4'd1;
        cw.rd_en = 1'b1;
        cw.nbr   = nbr_e'(4'(s - ST_RD0));
      end
      ST_WR: begin
        cw.cond  = C_LAST;
        cw.tgt_t = ST_PASS;
        cw.tgt_f = ST_PIX;
        cw.wr_en = 1'b1;
        cw.adv   = 1'b1;
      end
      ST_ADV: begin
        cw.cond  = C_LAST;
        cw.tgt_t = ST_PASS;
        cw.tgt_f = ST_PIX;
        cw.adv   = 1'b1;
      end
      ST_DONE: begin
        cw.cond  = C_ALWAYS;
        cw.tgt_t = ST_IDLE;
        cw.tgt_f = ST_IDLE;
        cw.push  = 1'b1;
      end
      default: begin
        cw.cond  = C_ALWAYS;
        cw.tgt_t = ST_IDLE;
        cw.tgt_f = ST_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== design/inplace_glyph_glow_blur_top.sv =====
// Top level of the in-place glyph glow blur: pixel store, microcoded
// sequencer, accumulator and output queue. Depends on iggb_pkg.
//
// Requests enter on the s_axis channel: a write stores one pixel, a read
// returns one pixel, a run applies the configured glow passes to the tile.
// Every request yields exactly one response on m_axis, in request order.
// Writes, reads and unused codes give their response through the return
// register and the output queue, one request per cycle while the receiver
// takes responses. A run holds off new requests until the sequencer is back
// at its idle step, also when the tile is empty. Each pixel costs a check
// step, nine reads through the single read port of the store and a write
// step; a pixel beyond the store costs a check and an advance step. Each
// pass costs one setup step. The APB port sets tile width, tile height and
// pass count; the user must write them only while idle, the block does not enforce it.
// Reset empties the output queue, parks the sequencer at its idle step and
// sets width 1, height 1, passes 0; the store contents stay undefined.
// Responses wait in a two-entry queue. When the receiver stalls and the
// queued responses plus the one on its way fill both entries, s_axis_tready
// drops until an entry is taken.
module inplace_glyph_glow_blur_top #(
  parameter int unsigned STORE_DEPTH = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel_index [15:0], pixel_value [23:16]
  input  logic [1:0]  s_axis_tuser,   // opcode [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // read_value [7:0], done_res [8], zero [15:9]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import iggb_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam logic [16:0] DepthLim = 17'(STORE_DEPTH);

  logic [7:0] mem_q [STORE_DEPTH];
  logic [7:0] rdata_q;

  logic [7:0]  width_q, height_q;
  logic [3:0]  passes_q;
  logic [3:0]  pass_left_q;
  logic [7:0]  row_q, col_q;
  logic [15:0] b_q;
  logic [15:0] area_q;
  logic [11:0] acc_q;
  logic        acc_pend_q, mask_q;
  logic        ret_vld_q, ret_rd_q;
  step_t       step_q, step_d;
  uc_word_t    uc;

  logic [7:0] fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  logic              in_acc, in_range, cfg_we, room, pop, push, cond_hit;
  logic              last_row, last_col, in_tile;
  op_e               in_op;
  logic [15:0]       in_idx;
  logic [7:0]        in_val;
  logic signed [17:0] off_s, nidx_s, b_s, w_s;
  logic [11:0]       sum_full;
  logic [8:0]        sum_sh;
  logic [7:0]        glow, push_val;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;

  assign in_op    = op_e'(s_axis_tuser);
  assign in_idx   = s_axis_tdata[15:0];
  assign in_val   = s_axis_tdata[23:16];
  assign in_range = {1'b0, in_idx} < DepthLim;
  assign uc       = ucode(step_q);
  assign pop      = m_axis_tvalid && m_axis_tready;
  assign room     = ({1'b0, cnt_q} + {2'b0, ret_vld_q}) <= (3'd1 + {2'b0, pop});
  assign s_axis_tready = uc.in_ready && room;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign last_row = row_q == (height_q - 8'd1);
  assign last_col = col_q == (width_q - 8'd1);

  // Neighbour address and tile bounds check.
  assign b_s = signed'({2'b00, b_q});
  assign w_s = signed'({10'd0, width_q});
  always_comb begin
    case (uc.nbr)
      NB_SELF:   off_s = 18'sd0;
      NB_RIGHT:  off_s = 18'sd1;
      NB_LEFT:   off_s = -18'sd1;
      NB_DOWN:   off_s = w_s;
      NB_UP:     off_s = -w_s;
      NB_DOWN_R: off_s = w_s + 18'sd1;
      NB_UP_L:   off_s = -w_s - 18'sd1;
      NB_DOWN_L: off_s = w_s - 18'sd1;
      NB_UP_R:   off_s = -w_s + 18'sd1;
      default:   off_s = 18'sd0;
    endcase
  end
  assign nidx_s  = b_s + off_s;
  assign in_tile = !nidx_s[17] && (nidx_s[16:0] < {1'b0, area_q}) &&
                   (nidx_s[16:0] < DepthLim);

  assign sum_full = acc_q + (mask_q ? {4'd0, rdata_q} : 12'd0);
  assign sum_sh   = sum_full[11:SumShift];
  assign glow     = sum_sh[8] ? PixMax : sum_sh[7:0];

  // Sequencer next step.
  always_comb begin
    case (uc.cond)
      C_ALWAYS:    cond_hit = 1'b1;
      C_RUN_START: cond_hit = in_acc && (in_op == OP_RUN);
      C_PASS_DONE: cond_hit = (pass_left_q == 4'd0) || (width_q == 8'd0) ||
                              (height_q == 8'd0);
      C_SKIP:      cond_hit = {1'b0, b_q} >= DepthLim;
      C_LAST:      cond_hit = last_row && last_col;
      default:     cond_hit = 1'b1;
    endcase
    step_d = cond_hit ? uc.tgt_t : uc.tgt_f;
  end

  // Store port controls.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = b_q[AW-1:0];
    mem_raddr = nidx_s[AW-1:0];
    mem_wdata = glow;
    if (uc.in_ready) begin
      mem_waddr = in_idx[AW-1:0];
      mem_raddr = in_idx[AW-1:0];
      mem_wdata = in_val;
      unique case (in_op)
        OP_WRITE: mem_we = in_acc && in_range;
        OP_READ:  mem_re = in_acc && in_range;
        default:  mem_we = 1'b0;
      endcase
    end else begin
      mem_we = uc.wr_en;
      mem_re = uc.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  always_comb begin
    unique case (paddr[3:2])
      REG_TILE_WIDTH:  prdata = {24'd0, width_q};
      REG_TILE_HEIGHT: prdata = {24'd0, height_q};
      REG_PASS_COUNT:  prdata = {28'd0, passes_q};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 8'd1;
      height_q <= 8'd1;
      passes_q <= 4'd0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_TILE_WIDTH:  width_q  <= pwdata[7:0];
        REG_TILE_HEIGHT: height_q <= pwdata[7:0];
        REG_PASS_COUNT:  passes_q <= pwdata[3:0];
        default:         passes_q <= passes_q;
      endcase
    end
  end

  // Sequencer control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      pass_left_q <= 4'd0;
      acc_pend_q  <= 1'b0;
      ret_vld_q   <= 1'b0;
      ret_rd_q    <= 1'b0;
    end else begin
      step_q     <= step_d;
      acc_pend_q <= uc.rd_en;
      ret_vld_q  <= in_acc && (in_op != OP_RUN);
      ret_rd_q   <= in_acc && (in_op == OP_READ) && in_range;
      if (in_acc && (in_op == OP_RUN)) begin
        pass_left_q <= passes_q;
      end else if (uc.pass_init && !cond_hit) begin
        pass_left_q <= pass_left_q - 4'd1;
      end
    end
  end

  // Pixel walk and accumulator.
  always_ff @(posedge clk_i) begin
    mask_q <= in_tile;
    if (uc.pass_init) begin
      row_q  <= 8'd0;
      col_q  <= 8'd0;
      b_q    <= 16'd0;
      area_q <= {8'd0, width_q} * {8'd0, height_q};
    end else if (uc.adv) begin
      if (last_row) begin
        row_q <= 8'd0;
        col_q <= col_q + 8'd1;
        b_q   <= {8'd0, col_q + 8'd1};
      end else begin
        row_q <= row_q + 8'd1;
        b_q   <= b_q + {8'd0, width_q};
      end
    end
    if (uc.acc_clr) begin
      acc_q <= 12'd0;
    end else if (acc_pend_q) begin
      acc_q <= sum_full;
    end
  end

  // Output queue.
  assign push     = ret_vld_q || uc.push;
  assign push_val = ret_rd_q ? rdata_q : 8'd0;
  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = {7'd0, 1'b1, fifo_q[rd_ptr_q]};

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/iggb_checker.sv =====
// Port-level checker for the glyph glow blur block, bound to its top level.
// Depends on iggb_pkg and inplace_glyph_glow_blur_top_assert.svh.
`include "inplace_glyph_glow_blur_top_assert.svh"

module iggb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  import iggb_pkg::*;

  `IGGB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "Stalled response changed.")

  `IGGB_ASSERT_NOW(a_out_format, m_axis_tvalid, m_axis_tdata[15:8] == 8'h01, "Response format is wrong.")

  `IGGB_ASSERT_NEXT(a_run_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_RUN, !s_axis_tready, "Run request did not hold off input.")

  `IGGB_ASSERT_NOW(a_quick_resp, s_axis_tvalid && s_axis_tready && s_axis_tuser != OP_RUN, ##2 m_axis_tvalid, "Response of a short request is late.")

endmodule

bind inplace_glyph_glow_blur_top iggb_checker u_iggb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
